@@ rtl/core/tgjc_pkg.sv @@
// ----------------------------------------------------------------------------
// tgjc_pkg
// Shared types, register codes and fixed-point constants of the tilt, gyro
// and joystick conditioner.
// ----------------------------------------------------------------------------
package tgjc_pkg;

  localparam int WINDOW_LEN_DEF = 20;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_GYRO_CENTER   = 2'd0,
    REG_GYRO_DEADBAND = 2'd1,
    REG_JOY_DEAD_MAG  = 2'd2
  } reg_idx_t;

  localparam logic [13:0] GYRO_CENTER_RST   = 14'd8180;
  localparam logic [9:0]  GYRO_DEADBAND_RST = 10'd30;
  localparam logic [12:0] JOY_DEAD_MAG_RST  = 13'd246;

  // expansion codes
  localparam logic [1:0] EXP_JOY  = 2'd1;
  localparam logic [1:0] EXP_GYRO = 2'd2;

  // joystick angle windows, 1/16 degree
  localparam logic [12:0] JOY_LEFT_LO  = 13'd3632;
  localparam logic [12:0] JOY_LEFT_HI  = 13'd5024;
  localparam logic [12:0] JOY_RIGHT_LO = 13'd672;
  localparam logic [12:0] JOY_RIGHT_HI = 13'd2144;
  localparam logic [12:0] Q12_ONE      = 13'd4096;

  // reciprocal scaling: q = (n * M) >> RECIP_K, M = ceil(2^RECIP_K / D)
  localparam int RECIP_K = 36;
  localparam longint unsigned CUR_DIV_X = 1200;
  localparam longint unsigned CUR_DIV_Y = 1000;
  localparam longint unsigned YAW_DIV   = 250;
  localparam longint unsigned CUR_X_M =
    ((64'd1 << RECIP_K) + CUR_DIV_X - 1) / CUR_DIV_X;
  localparam longint unsigned CUR_Y_M =
    ((64'd1 << RECIP_K) + CUR_DIV_Y - 1) / CUR_DIV_Y;
  localparam longint unsigned YAW_M =
    ((64'd1 << RECIP_K) + YAW_DIV - 1) / YAW_DIV;
  localparam logic [23:0] CUR_X_BIAS = 24'd600;
  localparam logic [23:0] CUR_Y_BIAS = 24'd500;
  localparam logic [23:0] YAW_BIAS   = 24'd125;
  localparam logic [18:0] YAW_MAG_MAX = 19'h7FFFF;
  localparam logic [15:0] U16_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [13:0] gyro_center;
    logic [9:0]  gyro_deadband;
    logic [12:0] joy_dead_mag;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               acc_on;
    logic signed [12:0] roll;
    logic signed [12:0] pitch;
    logic               cur_ok;
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic               home;
    logic               joy_upd;
    logic [12:0]        joy_l;
    logic [12:0]        joy_r;
    logic               yaw_int;
    logic signed [14:0] yaw_off;
  } item_t;

endpackage

@@ rtl/core/tgjc_if.sv @@
// ----------------------------------------------------------------------------
// tgjc_in_if / tgjc_out_if
// Valid/ready channels for sensor reports and conditioned results.
// ----------------------------------------------------------------------------
interface tgjc_in_if;
  logic               valid;
  logic               ready;
  logic               acc_on;
  logic signed [12:0] roll_deg;
  logic signed [12:0] pitch_deg;
  logic               ir_on;
  logic [9:0]         cursor_x;
  logic [9:0]         cursor_y;
  logic               home_pressed;
  logic [1:0]         expansion;
  logic [12:0]        joy_angle;
  logic [12:0]        joy_mag;
  logic [13:0]        gyro_z;

  modport source (output valid, acc_on, roll_deg, pitch_deg, ir_on, cursor_x, cursor_y,
                  home_pressed, expansion, joy_angle, joy_mag, gyro_z, input ready);
  modport sink (input valid, acc_on, roll_deg, pitch_deg, ir_on, cursor_x, cursor_y,
                home_pressed, expansion, joy_angle, joy_mag, gyro_z, output ready);
endinterface

interface tgjc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] roll_left;
  logic [14:0] roll_right;
  logic [14:0] pitch_front;
  logic [14:0] pitch_back;
  logic [12:0] cursor_x_norm;
  logic [12:0] cursor_y_norm;
  logic [12:0] joy_left;
  logic [12:0] joy_right;
  logic [15:0] yaw_left;
  logic [15:0] yaw_right;

  modport source (output valid, roll_left, roll_right, pitch_front, pitch_back,
                  cursor_x_norm, cursor_y_norm, joy_left, joy_right, yaw_left,
                  yaw_right, input ready);
  modport sink (input valid, roll_left, roll_right, pitch_front, pitch_back,
                cursor_x_norm, cursor_y_norm, joy_left, joy_right, yaw_left,
                yaw_right, output ready);
endinterface

@@ rtl/core/tgjc_regs.sv @@
// ----------------------------------------------------------------------------
// tgjc_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module tgjc_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output tgjc_pkg::cfg_t    cfg
);

  tgjc_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gyro_center   <= tgjc_pkg::GYRO_CENTER_RST;
      cfg_r.gyro_deadband <= tgjc_pkg::GYRO_DEADBAND_RST;
      cfg_r.joy_dead_mag  <= tgjc_pkg::JOY_DEAD_MAG_RST;
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        tgjc_pkg::REG_GYRO_CENTER:   cfg_r.gyro_center   <= cfg_pwdata[13:0];
        tgjc_pkg::REG_GYRO_DEADBAND: cfg_r.gyro_deadband <= cfg_pwdata[9:0];
        tgjc_pkg::REG_JOY_DEAD_MAG:  cfg_r.joy_dead_mag  <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      tgjc_pkg::REG_GYRO_CENTER:   cfg_prdata = {18'd0, cfg_r.gyro_center};
      tgjc_pkg::REG_GYRO_DEADBAND: cfg_prdata = {22'd0, cfg_r.gyro_deadband};
      tgjc_pkg::REG_JOY_DEAD_MAG:  cfg_prdata = {19'd0, cfg_r.joy_dead_mag};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/tgjc_front.sv @@
// ----------------------------------------------------------------------------
// tgjc_front
// Accepts sensor reports and classifies them: cursor gating, joystick
// direction pick and gyro dead band test.
// ----------------------------------------------------------------------------
module tgjc_front (
  tgjc_in_if.sink          in_ch,
  input  tgjc_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             push,
  output tgjc_pkg::item_t  item
);

  logic [12:0]        mag_c;
  logic               live;
  logic signed [14:0] off;
  logic [13:0]        off_abs;
  logic               is_gyro;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign is_gyro     = (in_ch.expansion == tgjc_pkg::EXP_GYRO);

  always_comb begin
    mag_c = (in_ch.joy_mag > tgjc_pkg::Q12_ONE) ? tgjc_pkg::Q12_ONE : in_ch.joy_mag;
    live  = (mag_c >= cfg.joy_dead_mag);
    off   = $signed({1'b0, in_ch.gyro_z}) - $signed({1'b0, cfg.gyro_center});
    off_abs = off[14] ? 14'(-off) : off[13:0];

    item.acc_on  = in_ch.acc_on;
    item.roll    = in_ch.roll_deg;
    item.pitch   = in_ch.pitch_deg;
    item.cur_ok  = in_ch.ir_on && (in_ch.cursor_x != 10'd0) && (in_ch.cursor_y != 10'd0);
    item.cx      = in_ch.cursor_x;
    item.cy      = in_ch.cursor_y;
    item.home    = in_ch.home_pressed;
    item.joy_upd = (in_ch.expansion == tgjc_pkg::EXP_JOY);
    item.joy_l   = 13'd0;
    item.joy_r   = 13'd0;
    if (live && in_ch.joy_angle >= tgjc_pkg::JOY_LEFT_LO
        && in_ch.joy_angle <= tgjc_pkg::JOY_LEFT_HI) begin
      item.joy_l = mag_c;
    end else if (live && in_ch.joy_angle >= tgjc_pkg::JOY_RIGHT_LO
                 && in_ch.joy_angle <= tgjc_pkg::JOY_RIGHT_HI) begin
      item.joy_r = mag_c;
    end
    item.yaw_int = is_gyro && (off_abs > {4'd0, cfg.gyro_deadband});
    item.yaw_off = off;
  end

endmodule

@@ rtl/core/tgjc_queue.sv @@
// ----------------------------------------------------------------------------
// tgjc_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tgjc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tgjc_pkg::item_t  push_item,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output tgjc_pkg::item_t  head_item
);

  logic [1:0]      count_r;
  tgjc_pkg::item_t ent0_r;
  tgjc_pkg::item_t ent1_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = ent0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      case ({push, pop && head_valid})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_valid) begin
      if (push && count_r == 2'd1) begin
        ent0_r <= push_item;
      end else begin
        ent0_r <= ent1_r;
      end
      if (push && count_r == 2'd2) begin
        ent1_r <= push_item;
      end
    end else if (push) begin
      if (count_r == 2'd0) begin
        ent0_r <= push_item;
      end else begin
        ent1_r <= push_item;
      end
    end
  end

endmodule

@@ rtl/core/tgjc_back.sv @@
// ----------------------------------------------------------------------------
// tgjc_back
// Carries out items: window sums, yaw integration, reciprocal scaling and
// the held result register.
// ----------------------------------------------------------------------------
module tgjc_back #(
  parameter int WINDOW_LEN = tgjc_pkg::WINDOW_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  tgjc_pkg::item_t  head_item,
  output logic             pop,
  tgjc_out_if.source       out_ch
);

  localparam int PW    = $clog2(WINDOW_LEN);
  localparam int SUM_W = 13 + $clog2(WINDOW_LEN);
  localparam int TN_W  = SUM_W + 9;
  localparam int TP_W  = TN_W + 32;
  localparam longint unsigned TILT_D   = 9 * WINDOW_LEN;
  localparam longint unsigned TILT_LIM = 1440 * WINDOW_LEN;
  localparam longint unsigned TILT_M   =
    ((64'd1 << tgjc_pkg::RECIP_K) + 2 * TILT_D - 1) / (2 * TILT_D);

  logic en;

  // window store and running sums
  logic [25:0]             win_mem [WINDOW_LEN];
  logic [25:0]             win_rd_r;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic                    filled_r;
  logic signed [SUM_W-1:0] roll_sum_r, pitch_sum_r;
  logic signed [SUM_W-1:0] roll_sum_nxt, pitch_sum_nxt;
  logic signed [12:0]      old_roll, old_pitch;
  logic [SUM_W-1:0]        roll_abs, pitch_abs;
  logic                    wrap;

  // yaw integral
  logic signed [31:0] yaw_r, yaw_base, yaw_new;
  logic signed [32:0] yaw_sum;
  logic [31:0]        yaw_abs;
  logic [18:0]        yaw_mag;

  // stage 1
  logic             s1_v_r;
  tgjc_pkg::item_t  s1_item_r;
  logic             s1_roll_ok_r, s1_roll_neg_r, s1_pitch_ok_r, s1_pitch_neg_r;
  logic [SUM_W-1:0] s1_roll_abs_r, s1_pitch_abs_r;
  logic             s1_yaw_pos_r;
  logic [18:0]      s1_yaw_mag_r;

  // stage 2
  logic             s2_v_r;
  tgjc_pkg::item_t  s2_item_r;
  logic             s2_roll_ok_r, s2_roll_neg_r, s2_pitch_ok_r, s2_pitch_neg_r;
  logic             s2_yaw_pos_r;
  logic [TP_W-1:0]  s2_roll_p_r, s2_pitch_p_r;
  logic [55:0]      s2_cx_p_r, s2_cy_p_r, s2_yaw_p_r;
  logic [TN_W-1:0]  roll_n, pitch_n;
  logic [23:0]      cx_n, cy_n, yaw_n;

  // output stage
  logic        out_v_r;
  logic [14:0] roll_q, pitch_q;
  logic [13:0] cx_q, cy_q;
  logic [16:0] yaw_q;
  logic [15:0] yaw_sat;
  logic [14:0] roll_left_r, roll_right_r, pitch_front_r, pitch_back_r;
  logic [12:0] cursor_x_r, cursor_y_r, joy_left_r, joy_right_r;
  logic [15:0] yaw_left_r, yaw_right_r;

  assign en  = !out_v_r || out_ch.ready;
  assign pop = en && head_valid;

  // ---------------- stage 1: state update ----------------
  always_comb begin
    old_roll      = filled_r ? $signed(win_rd_r[25:13]) : 13'sd0;
    old_pitch     = filled_r ? $signed(win_rd_r[12:0])  : 13'sd0;
    roll_sum_nxt  = roll_sum_r + SUM_W'(head_item.roll) - SUM_W'(old_roll);
    pitch_sum_nxt = pitch_sum_r + SUM_W'(head_item.pitch) - SUM_W'(old_pitch);
    roll_abs      = roll_sum_nxt[SUM_W-1] ? SUM_W'(-roll_sum_nxt) : SUM_W'(roll_sum_nxt);
    pitch_abs     = pitch_sum_nxt[SUM_W-1] ? SUM_W'(-pitch_sum_nxt)
                                           : SUM_W'(pitch_sum_nxt);
    wrap          = (pos_r == PW'(WINDOW_LEN - 1));
    pos_nxt       = pos_r;
    if (pop && head_item.acc_on) begin
      pos_nxt = wrap ? '0 : pos_r + 1'b1;
    end

    yaw_base = head_item.home ? 32'sd0 : yaw_r;
    yaw_sum  = {yaw_base[31], yaw_base} + 33'(head_item.yaw_off);
    if (yaw_sum[32] != yaw_sum[31]) begin
      // saturate at the 32-bit signed limits
      yaw_new = yaw_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      yaw_new = yaw_sum[31:0];
    end
    yaw_abs = yaw_new[31] ? 32'(-yaw_new) : 32'(yaw_new);
    yaw_mag = (yaw_abs > 32'(tgjc_pkg::YAW_MAG_MAX)) ? tgjc_pkg::YAW_MAG_MAX
                                                     : yaw_abs[18:0];
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.acc_on) begin
      win_mem[pos_r] <= {head_item.roll, head_item.pitch};
    end
    win_rd_r <= win_mem[pos_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      filled_r    <= 1'b0;
      roll_sum_r  <= '0;
      pitch_sum_r <= '0;
      yaw_r       <= 32'sd0;
    end else if (pop) begin
      pos_r <= pos_nxt;
      if (head_item.acc_on) begin
        roll_sum_r  <= roll_sum_nxt;
        pitch_sum_r <= pitch_sum_nxt;
        if (wrap) begin
          filled_r <= 1'b1;
        end
      end
      yaw_r <= head_item.yaw_int ? yaw_new : yaw_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r      <= head_item;
      s1_roll_ok_r   <= (roll_abs <= SUM_W'(TILT_LIM));
      s1_roll_neg_r  <= roll_sum_nxt[SUM_W-1];
      s1_roll_abs_r  <= roll_abs;
      s1_pitch_ok_r  <= (pitch_abs <= SUM_W'(TILT_LIM));
      s1_pitch_neg_r <= pitch_sum_nxt[SUM_W-1];
      s1_pitch_abs_r <= pitch_abs;
      s1_yaw_pos_r   <= (yaw_new > 32'sd0);
      s1_yaw_mag_r   <= yaw_mag;
    end
  end

  // ---------------- stage 2: reciprocal products ----------------
  always_comb begin
    // abs*320 plus the rounding half
    roll_n  = (TN_W'(s1_roll_abs_r) << 8) + (TN_W'(s1_roll_abs_r) << 6) + TN_W'(TILT_D);
    pitch_n = (TN_W'(s1_pitch_abs_r) << 8) + (TN_W'(s1_pitch_abs_r) << 6) + TN_W'(TILT_D);
    cx_n    = (24'(s1_item_r.cx) << 13) + tgjc_pkg::CUR_X_BIAS;
    cy_n    = (24'(s1_item_r.cy) << 13) + tgjc_pkg::CUR_Y_BIAS;
    yaw_n   = (24'(s1_yaw_mag_r) << 5) + tgjc_pkg::YAW_BIAS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item_r      <= s1_item_r;
      s2_roll_ok_r   <= s1_roll_ok_r;
      s2_roll_neg_r  <= s1_roll_neg_r;
      s2_pitch_ok_r  <= s1_pitch_ok_r;
      s2_pitch_neg_r <= s1_pitch_neg_r;
      s2_yaw_pos_r   <= s1_yaw_pos_r;
      s2_roll_p_r    <= TP_W'(roll_n) * TP_W'(32'(TILT_M));
      s2_pitch_p_r   <= TP_W'(pitch_n) * TP_W'(32'(TILT_M));
      s2_cx_p_r      <= 56'(cx_n) * 56'(32'(tgjc_pkg::CUR_X_M));
      s2_cy_p_r      <= 56'(cy_n) * 56'(32'(tgjc_pkg::CUR_Y_M));
      s2_yaw_p_r     <= 56'(yaw_n) * 56'(32'(tgjc_pkg::YAW_M));
    end
  end

  // ---------------- output stage: held results ----------------
  always_comb begin
    roll_q  = s2_roll_p_r[tgjc_pkg::RECIP_K +: 15];
    pitch_q = s2_pitch_p_r[tgjc_pkg::RECIP_K +: 15];
    cx_q    = s2_cx_p_r[tgjc_pkg::RECIP_K +: 14];
    cy_q    = s2_cy_p_r[tgjc_pkg::RECIP_K +: 14];
    yaw_q   = s2_yaw_p_r[tgjc_pkg::RECIP_K +: 17];
    yaw_sat = yaw_q[16] ? tgjc_pkg::U16_MAX : yaw_q[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      roll_left_r   <= '0;
      roll_right_r  <= '0;
      pitch_front_r <= '0;
      pitch_back_r  <= '0;
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      joy_left_r    <= '0;
      joy_right_r   <= '0;
      yaw_left_r    <= '0;
      yaw_right_r   <= '0;
    end else if (en) begin
      out_v_r <= s2_v_r;
      if (s2_v_r) begin
        // tilt beyond ninety degrees keeps the axis outputs
        if (s2_item_r.acc_on && s2_roll_ok_r) begin
          roll_left_r  <= s2_roll_neg_r ? roll_q : 15'd0;
          roll_right_r <= s2_roll_neg_r ? 15'd0 : roll_q;
        end
        if (s2_item_r.acc_on && s2_pitch_ok_r) begin
          pitch_back_r  <= s2_pitch_neg_r ? pitch_q : 15'd0;
          pitch_front_r <= s2_pitch_neg_r ? 15'd0 : pitch_q;
        end
        if (s2_item_r.cur_ok) begin
          cursor_x_r <= (cx_q > 14'(tgjc_pkg::Q12_ONE)) ? tgjc_pkg::Q12_ONE : cx_q[12:0];
          cursor_y_r <= (cy_q > 14'(tgjc_pkg::Q12_ONE)) ? tgjc_pkg::Q12_ONE : cy_q[12:0];
        end
        if (s2_item_r.joy_upd) begin
          joy_left_r  <= s2_item_r.joy_l;
          joy_right_r <= s2_item_r.joy_r;
        end
        if (s2_item_r.yaw_int) begin
          yaw_left_r  <= s2_yaw_pos_r ? yaw_sat : 16'd0;
          yaw_right_r <= s2_yaw_pos_r ? 16'd0 : yaw_sat;
        end
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.roll_left     = roll_left_r;
  assign out_ch.roll_right    = roll_right_r;
  assign out_ch.pitch_front   = pitch_front_r;
  assign out_ch.pitch_back    = pitch_back_r;
  assign out_ch.cursor_x_norm = cursor_x_r;
  assign out_ch.cursor_y_norm = cursor_y_r;
  assign out_ch.joy_left      = joy_left_r;
  assign out_ch.joy_right     = joy_right_r;
  assign out_ch.yaw_left      = yaw_left_r;
  assign out_ch.yaw_right     = yaw_right_r;

endmodule

@@ rtl/core/tilt_gyro_joystick_conditioner.sv @@
// ----------------------------------------------------------------------------
// tilt_gyro_joystick_conditioner
// Conditions controller sensor reports into tilt, cursor, stick and yaw
// results, one result item per report item.
//
// in_ch carries one sensor report per item, out_ch one result item per
// report, in order. The cfg_ APB port sets gyro center, gyro dead band and
// stick dead zone; write it only while no item is in flight.
// After its report is accepted, a result item passes the queue, the state
// stage, the product stage and the output register in order. Throughput is one
// item per cycle while out_ch does not stall: the window sums and the yaw
// integral update in a single stage, and every divide by a constant is one
// registered reciprocal multiply.
// The moving-average window lives in a WINDOW_LEN deep memory; a fill flag
// makes unwritten slots read as zero, so no clearing pass runs after reset.
// Reset (rst_n low, synchronous) zeroes sums, yaw total, held results and
// empties the queue; registers return to their defaults.
// When out_ch.ready is low while a result is valid, the back stages hold,
// the two-entry queue fills, and in_ch.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module tilt_gyro_joystick_conditioner #(
  parameter int WINDOW_LEN = tgjc_pkg::WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tgjc_in_if.sink     in_ch,
  tgjc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tgjc_pkg::cfg_t  cfg;
  tgjc_pkg::item_t push_item;
  tgjc_pkg::item_t head_item;
  logic            push, pop, q_full, head_valid;

  tgjc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tgjc_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  tgjc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tgjc_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt, gyro and joystick conditioner. A directed
// table and random reports drive the input channel. A behavioral model of
// the window averages, cursor scaling, stick windows and yaw integral
// predicts each result item, and the bench compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WLEN      = tgjc_pkg::WINDOW_LEN_DEF;
  localparam int N_RANDOM  = 1250;
  localparam int STALL_MAX = 4000;
  localparam int N_DIR     = 22;

  typedef struct packed {
    logic               acc_on;
    logic signed [12:0] roll;
    logic signed [12:0] pitch;
    logic               ir_on;
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic               home;
    logic [1:0]         expn;
    logic [12:0]        ang;
    logic [12:0]        mag;
    logic [13:0]        gz;
  } report_t;

  typedef struct packed {
    logic [14:0] roll_l;
    logic [14:0] roll_r;
    logic [14:0] pitch_f;
    logic [14:0] pitch_b;
    logic [12:0] cur_x;
    logic [12:0] cur_y;
    logic [12:0] joy_l;
    logic [12:0] joy_r;
    logic [15:0] yaw_l;
    logic [15:0] yaw_r;
  } cond_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tgjc_in_if  in_ch ();
  tgjc_out_if out_ch ();

  tilt_gyro_joystick_conditioner u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [13:0] m_center;
  logic [9:0]  m_dband;
  logic [12:0] m_jdead;
  int          roll_win[WLEN];
  int          pitch_win[WLEN];
  int          roll_acc;
  int          pitch_acc;
  int          win_slot;
  longint      yaw_acc;
  cond_t       held;

  cond_t  cond_q[$];
  int     n_errors;
  int     idle_cycles;
  bit     sending_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [14:0] tilt_pct(longint m);
    longint d;
    d = 9 * WLEN;
    return 15'((m * 320 + d) / (2 * d));
  endfunction

  function automatic logic [12:0] cur_scale(int v, int dv);
    int r;
    r = (v * 8192 + dv) / (2 * dv);
    return (r > 4096) ? 13'd4096 : 13'(r);
  endfunction

  function automatic logic [15:0] yaw_scale(longint t);
    longint r;
    r = (t * 32 + 125) / 250;
    return (r > 65535) ? 16'hFFFF : 16'(r);
  endfunction

  task automatic model_reset();
    m_center = tgjc_pkg::GYRO_CENTER_RST;
    m_dband  = tgjc_pkg::GYRO_DEADBAND_RST;
    m_jdead  = tgjc_pkg::JOY_DEAD_MAG_RST;
    foreach (roll_win[i]) begin
      roll_win[i]  = 0;
      pitch_win[i] = 0;
    end
    roll_acc  = 0;
    pitch_acc = 0;
    win_slot  = 0;
    yaw_acc   = 0;
    held      = '0;
  endtask

  task automatic split_axis(int s, output logic [14:0] neg, output logic [14:0] pos,
                            input logic [14:0] neg_old, input logic [14:0] pos_old);
    longint lim;
    lim = 1440 * WLEN;
    neg = neg_old;
    pos = pos_old;
    if (s >= 0 && s <= lim) begin
      pos = tilt_pct(s);
      neg = '0;
    end else if (s < 0 && -s <= lim) begin
      neg = tilt_pct(-s);
      pos = '0;
    end
  endtask

  // advance the model by one report and queue its conditioned result
  task automatic predict_report(report_t r);
    int     off;
    int     m;
    longint t;
    if (r.home) yaw_acc = 0;
    if (r.acc_on) begin
      roll_acc  += int'(r.roll) - roll_win[win_slot];
      pitch_acc += int'(r.pitch) - pitch_win[win_slot];
      roll_win[win_slot]  = int'(r.roll);
      pitch_win[win_slot] = int'(r.pitch);
      win_slot = (win_slot + 1 >= WLEN) ? 0 : win_slot + 1;
      split_axis(roll_acc, held.roll_l, held.roll_r, held.roll_l, held.roll_r);
      split_axis(pitch_acc, held.pitch_b, held.pitch_f, held.pitch_b, held.pitch_f);
    end
    if (r.ir_on && r.cx != 0 && r.cy != 0) begin
      held.cur_x = cur_scale(int'(r.cx), 600);
      held.cur_y = cur_scale(int'(r.cy), 500);
    end
    if (r.expn == tgjc_pkg::EXP_JOY) begin
      m = (r.mag > 4096) ? 4096 : int'(r.mag);
      held.joy_l = '0;
      held.joy_r = '0;
      if (r.ang >= tgjc_pkg::JOY_LEFT_LO && r.ang <= tgjc_pkg::JOY_LEFT_HI && m >= m_jdead)
        held.joy_l = 13'(m);
      else if (r.ang >= tgjc_pkg::JOY_RIGHT_LO && r.ang <= tgjc_pkg::JOY_RIGHT_HI
               && m >= m_jdead)
        held.joy_r = 13'(m);
    end else if (r.expn == tgjc_pkg::EXP_GYRO) begin
      off = int'(r.gz) - int'(m_center);
      if ((off < 0 ? -off : off) > int'(m_dband)) begin
        t = yaw_acc + off;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        yaw_acc = t;
        if (t > 0) begin
          held.yaw_l = yaw_scale(t);
          held.yaw_r = '0;
        end else begin
          held.yaw_r = yaw_scale(-t);
          held.yaw_l = '0;
        end
      end
    end
    cond_q.push_back(held);
  endtask

  task automatic cfg_write(tgjc_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 4'(idx) << 2;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      tgjc_pkg::REG_GYRO_CENTER:   m_center = val[13:0];
      tgjc_pkg::REG_GYRO_DEADBAND: m_dband  = val[9:0];
      default:                     m_jdead  = val[12:0];
    endcase
  endtask

  task automatic send_report(report_t r);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.acc_on       <= r.acc_on;
    in_ch.roll_deg     <= r.roll;
    in_ch.pitch_deg    <= r.pitch;
    in_ch.ir_on        <= r.ir_on;
    in_ch.cursor_x     <= r.cx;
    in_ch.cursor_y     <= r.cy;
    in_ch.home_pressed <= r.home;
    in_ch.expansion    <= r.expn;
    in_ch.joy_angle    <= r.ang;
    in_ch.joy_mag      <= r.mag;
    in_ch.gyro_z       <= r.gz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_report(r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cond_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic report_t random_report(int mode);
    report_t r;
    r.acc_on = ($urandom_range(0, 7) != 0);
    r.roll   = 13'($signed($urandom_range(0, 5760)) - 2880);
    r.pitch  = 13'($signed($urandom_range(0, 5760)) - 2880);
    if (mode == 0) begin
      // sustained tilt past ninety degrees
      r.roll  = ($urandom_range(0, 1)) ? 13'sd2880 : -13'sd2880;
      r.pitch = ($urandom_range(0, 1)) ? 13'sd2000 : -13'sd2400;
    end
    r.ir_on = $urandom_range(0, 1);
    r.cx    = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    r.cy    = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    r.home  = ($urandom_range(0, 15) == 0);
    r.expn  = 2'($urandom_range(0, 3));
    r.ang   = ($urandom_range(0, 15) == 0) ? 13'($urandom_range(0, 8191))
                                           : 13'($urandom_range(0, 5759));
    r.mag   = 13'($urandom_range(0, 8191));
    if (mode == 1)
      r.gz = ($urandom_range(0, 1)) ? 14'h3FFF : 14'd0;
    else
      r.gz = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                         : 14'(int'(m_center) + $urandom_range(0, 200) - 100);
    return r;
  endfunction

  // directed rows: report plus an optional typed-in result
  report_t dir_in[N_DIR];
  cond_t   dir_out[N_DIR];
  bit      dir_has[N_DIR];

  task automatic fill_table();
    report_t z;
    z = '0;
    foreach (dir_in[i]) begin
      dir_in[i]  = z;
      dir_has[i] = 1'b0;
      dir_out[i] = '0;
    end
    dir_has[0] = 1'b1;                                   // nothing valid after reset
    dir_in[1] = z; dir_in[1].ir_on = 1; dir_in[1].cx = 10'd1023; dir_in[1].cy = 10'd1023;
    dir_has[1] = 1'b1; dir_out[1].cur_x = 13'd4096; dir_out[1].cur_y = 13'd4096;
    dir_in[2] = z; dir_in[2].ir_on = 1; dir_in[2].cx = 10'd0; dir_in[2].cy = 10'd5;
    dir_has[2] = 1'b1; dir_out[2].cur_x = 13'd4096; dir_out[2].cur_y = 13'd4096;
    dir_in[3] = z; dir_in[3].ir_on = 1; dir_in[3].cx = 10'd1; dir_in[3].cy = 10'd1;
    dir_in[4] = z; dir_in[4].expn = tgjc_pkg::EXP_JOY; dir_in[4].ang = tgjc_pkg::JOY_LEFT_LO;
    dir_in[4].mag = 13'd8191;
    dir_in[5] = z; dir_in[5].expn = tgjc_pkg::EXP_JOY;
    dir_in[5].ang = tgjc_pkg::JOY_RIGHT_HI;
    dir_in[5].mag = 13'd246;
    dir_in[6] = z; dir_in[6].expn = tgjc_pkg::EXP_JOY; dir_in[6].ang = 13'd5759;
    dir_in[6].mag = 13'd4096;
    dir_in[7] = z; dir_in[7].expn = tgjc_pkg::EXP_JOY;
    dir_in[7].ang = tgjc_pkg::JOY_RIGHT_LO;
    dir_in[7].mag = 13'd245;
    dir_in[8] = z; dir_in[8].expn = tgjc_pkg::EXP_GYRO; dir_in[8].gz = 14'h3FFF;
    dir_in[9] = z; dir_in[9].expn = tgjc_pkg::EXP_GYRO; dir_in[9].gz = 14'd8210;
    dir_in[10] = z; dir_in[10].expn = tgjc_pkg::EXP_GYRO; dir_in[10].gz = 14'd8211;
    dir_in[11] = z; dir_in[11].home = 1; dir_in[11].expn = tgjc_pkg::EXP_GYRO;
    dir_in[11].gz = 14'd0;
    dir_in[12] = z; dir_in[12].home = 1;
    dir_in[13] = z; dir_in[13].expn = 2'd3; dir_in[13].gz = 14'h3FFF;
    dir_in[13].mag = 13'h1FFF; dir_in[13].ang = 13'd1000;
    for (int i = 14; i < N_DIR; i++) begin
      dir_in[i] = z;
      dir_in[i].acc_on = 1;
      dir_in[i].roll   = (i % 2) ? 13'sd2880 : -13'sd2880;
      dir_in[i].pitch  = (i % 3) ? -13'sd2880 : 13'sd1440;
    end
  endtask

  // result checker with random back-pressure
  initial begin : recv
    int    stall;
    cond_t e;
    cond_t a;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      a = {out_ch.roll_left, out_ch.roll_right, out_ch.pitch_front, out_ch.pitch_back,
           out_ch.cursor_x_norm, out_ch.cursor_y_norm, out_ch.joy_left, out_ch.joy_right,
           out_ch.yaw_left, out_ch.yaw_right};
      if (cond_q.size() == 0) begin
        $error("result item with no expectation");
        n_errors++;
      end else begin
        e = cond_q.pop_front();
        if (a.roll_l !== e.roll_l) begin
          $error("roll_left exp %0d got %0d", e.roll_l, a.roll_l); n_errors++;
        end
        if (a.roll_r !== e.roll_r) begin
          $error("roll_right exp %0d got %0d", e.roll_r, a.roll_r); n_errors++;
        end
        if (a.pitch_f !== e.pitch_f) begin
          $error("pitch_front exp %0d got %0d", e.pitch_f, a.pitch_f); n_errors++;
        end
        if (a.pitch_b !== e.pitch_b) begin
          $error("pitch_back exp %0d got %0d", e.pitch_b, a.pitch_b); n_errors++;
        end
        if (a.cur_x !== e.cur_x) begin
          $error("cursor_x_norm exp %0d got %0d", e.cur_x, a.cur_x); n_errors++;
        end
        if (a.cur_y !== e.cur_y) begin
          $error("cursor_y_norm exp %0d got %0d", e.cur_y, a.cur_y); n_errors++;
        end
        if (a.joy_l !== e.joy_l) begin
          $error("joy_left exp %0d got %0d", e.joy_l, a.joy_l); n_errors++;
        end
        if (a.joy_r !== e.joy_r) begin
          $error("joy_right exp %0d got %0d", e.joy_r, a.joy_r); n_errors++;
        end
        if (a.yaw_l !== e.yaw_l) begin
          $error("yaw_left exp %0d got %0d", e.yaw_l, a.yaw_l); n_errors++;
        end
        if (a.yaw_r !== e.yaw_r) begin
          $error("yaw_right exp %0d got %0d", e.yaw_r, a.yaw_r); n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n ||
          (sending_done && cond_q.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stim
    int phase;
    n_errors     = 0;
    sending_done = 1'b0;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_ch.valid  = 1'b0;
    {in_ch.acc_on, in_ch.roll_deg, in_ch.pitch_deg, in_ch.ir_on, in_ch.cursor_x,
     in_ch.cursor_y, in_ch.home_pressed, in_ch.expansion, in_ch.joy_angle,
     in_ch.joy_mag, in_ch.gyro_z} = '0;
    model_reset();
    fill_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_report(dir_in[i]);
      if (dir_has[i] && cond_q[$] !== dir_out[i]) begin
        $error("directed row %0d: table exp %h model %h", i, dir_out[i], cond_q[$]);
        n_errors++;
      end
    end
    drain();

    // several register settings, extremes included
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          cfg_write(tgjc_pkg::REG_GYRO_CENTER, 32'd0);
          cfg_write(tgjc_pkg::REG_GYRO_DEADBAND, 32'd0);
          cfg_write(tgjc_pkg::REG_JOY_DEAD_MAG, 32'd0);
        end
        1: begin
          cfg_write(tgjc_pkg::REG_GYRO_CENTER, 32'd16383);
          cfg_write(tgjc_pkg::REG_GYRO_DEADBAND, 32'd1023);
          cfg_write(tgjc_pkg::REG_JOY_DEAD_MAG, 32'd4096);
        end
        2: begin
          cfg_write(tgjc_pkg::REG_GYRO_CENTER, 32'($urandom_range(0, 16383)));
          cfg_write(tgjc_pkg::REG_GYRO_DEADBAND, 32'($urandom_range(0, 1023)));
          cfg_write(tgjc_pkg::REG_JOY_DEAD_MAG, 32'($urandom_range(0, 8191)));
        end
        3: begin
          cfg_write(tgjc_pkg::REG_GYRO_CENTER, 32'd8180);
          cfg_write(tgjc_pkg::REG_GYRO_DEADBAND, 32'd30);
          cfg_write(tgjc_pkg::REG_JOY_DEAD_MAG, 32'd246);
        end
        default: begin
          cfg_write(tgjc_pkg::REG_GYRO_CENTER, 32'd0);
          cfg_write(tgjc_pkg::REG_GYRO_DEADBAND, 32'd1);
          cfg_write(tgjc_pkg::REG_JOY_DEAD_MAG, 32'd4097);
        end
      endcase
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        // saturation runs drive the yaw magnitude into its output clamp
        send_report(random_report((k % 97 < 8) ? 0 : (phase == 4 && k % 50 < 40) ? 1 : 2));
        if (k == 100) drain();
      end
      drain();
    end

    sending_done = 1'b1;
    repeat (10) @(posedge clk);
    if (n_errors == 0 && cond_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
